[hw/rtl/lmc_pkg.sv]
// Shared types, constants, mode tables and helper functions for the light mode controller.
package lmc_pkg;

	localparam int MODE_COUNT           = 20;
	localparam int SOLID_COUNT          = 6;
	localparam int FIRST_PRIMARY_HIDDEN = 16;
	localparam int CFG_IDX_W            = 3;

	localparam logic [7:0] PATTERN_CODE_LOW = 8'd245;
	localparam logic [7:0] TURBO_CODE       = 8'd255;
	localparam logic [3:0] LOW_COUNT_MAX    = 4'd15;

	// Mode after a turbo step-down from a hidden mode, and after a low-voltage one.
	localparam logic [4:0] TURBO_HIDDEN_MODE = 5'd4;
	localparam logic [4:0] LV_HIDDEN_MODE    = 5'd2;

	typedef logic [4:0] mode_t;

	typedef enum logic {
		CMD_POWER_UP = 1'b0,
		CMD_TICK     = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SHORT_THR    = 3'd0,
		CFG_MEDIUM_THR   = 3'd1,
		CFG_TURBO_TICKS  = 3'd2,
		CFG_TURBO_MIN    = 3'd3,
		CFG_LV_THR       = 3'd4,
		CFG_LOW_NEEDED   = 3'd5
	} cfg_idx_t;

	localparam logic [7:0] MAIN_CODE [MODE_COUNT] = '{
		8'd0,   8'd0,   8'd3,   8'd33,  8'd110, 8'd255,
		8'd253, 8'd252, 8'd251, 8'd254, 8'd247, 8'd250, 8'd249, 8'd248, 8'd246, 8'd245,
		8'd254, 8'd249, 8'd251, 8'd255
	};

	localparam logic [7:0] ALT_CODE [MODE_COUNT] = '{
		8'd3, 8'd20, 8'd150, 8'd255, 8'd255, 8'd0,
		8'd0, 8'd0,  8'd0,   8'd0,   8'd0,   8'd0, 8'd0, 8'd0, 8'd0, 8'd6,
		8'd10, 8'd11, 8'd6, 8'd0
	};

	localparam logic FAST_CODE [MODE_COUNT] = '{
		1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0
	};

	typedef struct packed {
		logic [7:0] short_press_threshold;
		logic [7:0] medium_press_threshold;
		logic [7:0] turbo_timeout_ticks;
		logic [7:0] turbo_min_level;
		logic [7:0] low_voltage_threshold;
		logic [3:0] low_samples_needed;
	} cfg_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] cap_value;
		logic       stored_found;
		logic [7:0] stored_mode;
		logic       voltage_valid;
		logic [7:0] voltage_sample;
	} item_t;

	typedef struct packed {
		mode_t      mode_index;
		logic [7:0] main_level;
		logic [7:0] alt_level;
		logic       fast_pwm;
		logic [3:0] pattern;
		logic       save_request;
		logic       shutdown;
	} result_t;

	function automatic mode_t safe_mode(input logic [7:0] m);
		return (m < 8'(MODE_COUNT)) ? m[4:0] : '0;
	endfunction

	function automatic logic is_pattern(input logic [7:0] code);
		return (code >= PATTERN_CODE_LOW) && (code != TURBO_CODE);
	endfunction

	// Short press: next mode, wrap solid modes, hidden loops jump via the alt table.
	function automatic mode_t short_press_mode(input mode_t m);
		mode_t n;
		n = m + 5'd1;
		if (n == 5'(SOLID_COUNT))
			return '0;
		if (n >= 5'(FIRST_PRIMARY_HIDDEN))
			return safe_mode(ALT_CODE[m]);
		return n;
	endfunction

	// Medium press: previous mode, with hidden-mode loops.
	function automatic mode_t medium_press_mode(input mode_t m);
		if (m == 5'(FIRST_PRIMARY_HIDDEN))
			return '0;
		if (m == 5'(SOLID_COUNT))
			return 5'(FIRST_PRIMARY_HIDDEN - 1);
		if (m != '0)
			return m - 5'd1;
		return 5'(MODE_COUNT - 1);
	endfunction

endpackage

[hw/rtl/lmc_ifs.sv]
// Handshake channel interfaces: input items, result items and configuration writes.
interface lmc_item_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] cap_value;
	logic       stored_found;
	logic [7:0] stored_mode;
	logic       voltage_valid;
	logic [7:0] voltage_sample;

	modport source (
		output valid, cmd, cap_value, stored_found, stored_mode, voltage_valid, voltage_sample,
		input  ready
	);
	modport sink (
		input  valid, cmd, cap_value, stored_found, stored_mode, voltage_valid, voltage_sample,
		output ready
	);
endinterface

interface lmc_result_if;
	logic       valid;
	logic       ready;
	logic [4:0] mode_index;
	logic [7:0] main_level;
	logic [7:0] alt_level;
	logic       fast_pwm;
	logic [3:0] pattern;
	logic       save_request;
	logic       shutdown;

	modport source (
		output valid, mode_index, main_level, alt_level, fast_pwm, pattern, save_request,
			shutdown,
		input  ready
	);
	modport sink (
		input  valid, mode_index, main_level, alt_level, fast_pwm, pattern, save_request,
			shutdown,
		output ready
	);
endinterface

interface lmc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [lmc_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                     wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

[hw/rtl/lmc_cfg_regs.sv]
// Configuration register file for the light mode controller.
module lmc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_valid,
	output logic                           wr_ready,
	input  logic [lmc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [7:0]                     wr_data,
	output lmc_pkg::cfg_t                  cfg
);
	import lmc_pkg::*;

	cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_press_threshold  <= 8'd250;
			cfg_q.medium_press_threshold <= 8'd190;
			cfg_q.turbo_timeout_ticks    <= 8'd30;
			cfg_q.turbo_min_level        <= 8'd100;
			cfg_q.low_voltage_threshold  <= 8'd116;
			cfg_q.low_samples_needed     <= 4'd8;
		end else if (wr_valid) begin
			case (cfg_idx_t'(wr_index))
				CFG_SHORT_THR:   cfg_q.short_press_threshold  <= wr_data;
				CFG_MEDIUM_THR:  cfg_q.medium_press_threshold <= wr_data;
				CFG_TURBO_TICKS: cfg_q.turbo_timeout_ticks    <= wr_data;
				CFG_TURBO_MIN:   cfg_q.turbo_min_level        <= wr_data;
				CFG_LV_THR:      cfg_q.low_voltage_threshold  <= wr_data;
				CFG_LOW_NEEDED:  cfg_q.low_samples_needed     <= wr_data[3:0];
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/lmc_core.sv]
// Mode state registers, next-mode logic and result decode for one item.
module lmc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  lmc_pkg::cfg_t    cfg,
	input  lmc_pkg::item_t   item,
	input  logic             advance,
	output lmc_pkg::result_t res
);
	import lmc_pkg::*;

	mode_t      mode_q;
	logic [7:0] turbo_q;
	logic [3:0] low_q;
	logic       halted_q;

	mode_t      mode_d;
	logic [7:0] turbo_d;
	logic [3:0] low_d;
	logic       halted_d;
	logic       save;
	logic       off;

	mode_t      base_mode;
	mode_t      step_mode;
	logic [7:0] cur_code;
	logic [7:0] tick_cnt;
	logic [3:0] low_cnt;
	logic [3:0] need;
	logic [7:0] out_code;
	logic [7:0] pat_diff;

	always_comb begin
		mode_d    = mode_q;
		turbo_d   = turbo_q;
		low_d     = low_q;
		halted_d  = halted_q;
		save      = 1'b0;
		off       = 1'b0;
		base_mode = item.stored_found ? safe_mode(item.stored_mode) : '0;
		step_mode = mode_q;
		cur_code  = MAIN_CODE[mode_q];
		tick_cnt  = turbo_q + 8'd1;
		low_cnt   = low_q;
		need      = (cfg.low_samples_needed == 4'd0) ? 4'd1 : cfg.low_samples_needed;

		if (item.cmd == CMD_POWER_UP) begin
			if (item.cap_value > cfg.short_press_threshold)
				mode_d = short_press_mode(base_mode);
			else if (item.cap_value > cfg.medium_press_threshold)
				mode_d = medium_press_mode(base_mode);
			else
				mode_d = '0;
			turbo_d  = '0;
			low_d    = '0;
			halted_d = 1'b0;
			save     = 1'b1;
		end else if (halted_q) begin
			off = 1'b1;
		end else begin
			// Turbo step-down, non-pattern modes only
			if (!is_pattern(cur_code)) begin
				if (tick_cnt > cfg.turbo_timeout_ticks && cur_code >= cfg.turbo_min_level) begin
					if (mode_q >= 5'(SOLID_COUNT))
						step_mode = TURBO_HIDDEN_MODE;
					else if (mode_q != '0)
						step_mode = mode_q - 5'd1;
					tick_cnt = '0;
					save     = 1'b1;
				end
				turbo_d = tick_cnt;
			end

			// Low-voltage step-down
			if (item.voltage_valid) begin
				if (item.voltage_sample < cfg.low_voltage_threshold)
					low_cnt = (low_q == LOW_COUNT_MAX) ? low_q : low_q + 4'd1;
				else
					low_cnt = '0;
				if (low_cnt >= need) begin
					low_cnt = '0;
					if (step_mode >= 5'(SOLID_COUNT)) begin
						step_mode = LV_HIDDEN_MODE;
						save      = 1'b1;
					end else if (step_mode != '0) begin
						step_mode = step_mode - 5'd1;
						save      = 1'b1;
					end else begin
						halted_d = 1'b1;
						off      = 1'b1;
						save     = 1'b0;
					end
				end
				low_d = low_cnt;
			end
			mode_d = step_mode;
		end
	end

	// Result decode from the updated mode
	always_comb begin
		out_code         = MAIN_CODE[mode_d];
		pat_diff         = TURBO_CODE - out_code;
		res.mode_index   = mode_d;
		res.main_level   = '0;
		res.alt_level    = '0;
		res.fast_pwm     = 1'b0;
		res.pattern      = '0;
		res.save_request = save;
		res.shutdown     = off;
		if (!off) begin
			if (is_pattern(out_code)) begin
				res.pattern = pat_diff[3:0];
			end else begin
				res.main_level = out_code;
				res.alt_level  = ALT_CODE[mode_d];
				res.fast_pwm   = (out_code == 8'd0 && ALT_CODE[mode_d] == 8'd0) ?
					1'b0 : FAST_CODE[mode_d];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			turbo_q  <= '0;
			low_q    <= '0;
			halted_q <= 1'b0;
		end else if (advance) begin
			mode_q   <= mode_d;
			turbo_q  <= turbo_d;
			low_q    <= low_d;
			halted_q <= halted_d;
		end
	end

endmodule

[hw/rtl/light_mode_controller.sv]
// Top level of the two-channel light mode controller.
// Each transaction on the item channel is either a power-up event or a half-second tick,
// and produces exactly one result transaction with the mode, channel levels, PWM kind,
// blink pattern, save request and shutdown flag. The block sustains one transaction per
// clock while the result side keeps up: the input register holds an item, and in the cycle it
// moves to the result register the mode state updates, so the next item already sees it.
// An accepted item is held in the input register, then in the result register. The result
// register frees the input side from a stalled consumer: a new item is taken while a finished
// result still waits, as long as the input register can drain. Configuration writes are taken
// in any cycle, but must only be issued while no item is in flight.
module light_mode_controller (
	input  logic          clk,
	input  logic          arst_n,
	lmc_item_if.sink      item,
	lmc_result_if.source  result,
	lmc_cfg_if.sink       cfg
);
	import lmc_pkg::*;

	cfg_t    cfg_regs;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_q;
	logic    res_valid_q;
	logic    advance;

	// Move the held item on when the result register is empty or being drained.
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	lmc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.wdata),
		.cfg      (cfg_regs)
	);

	lmc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_regs),
		.item    (item_s1),
		.advance (advance),
		.res     (res_d)
	);

	// Input register: capture on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.cmd            <= item.cmd;
			item_s1.cap_value      <= item.cap_value;
			item_s1.stored_found   <= item.stored_found;
			item_s1.stored_mode    <= item.stored_mode;
			item_s1.voltage_valid  <= item.voltage_valid;
			item_s1.voltage_sample <= item.voltage_sample;
		end
	end

	// Result register: load when the core advances, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.mode_index   = res_q.mode_index;
	assign result.main_level   = res_q.main_level;
	assign result.alt_level    = res_q.alt_level;
	assign result.fast_pwm     = res_q.fast_pwm;
	assign result.pattern      = res_q.pattern;
	assign result.save_request = res_q.save_request;
	assign result.shutdown     = res_q.shutdown;

endmodule
